// File: src/bst_pkg.sv
// shared constants, types and codes of the bencode stream tokenizer
`default_nettype none

package bst_pkg;

	localparam int MAX_DEPTH   = 32;
	localparam int DIGIT_LIMIT = 15;

	// bits needed for the largest value of DIGIT_LIMIT decimal digits
	function automatic int acc_bits(input int limit);
		longint unsigned p;
		int n;
		p = 64'd1;
		n = 0;
		for (int i = 0; i < limit; i++) begin
			p = p * 64'd10;
		end
		p = p - 64'd1;
		while ((p >> n) != 64'd0) begin
			n++;
		end
		return n;
	endfunction

	localparam int ACC_W   = acc_bits(DIGIT_LIMIT);
	localparam int MUL_W   = ACC_W + 4;
	localparam int DCNT_W  = $clog2(DIGIT_LIMIT + 1);
	localparam int LEVEL_W = $clog2(MAX_DEPTH + 1);
	localparam int STK_W   = (MAX_DEPTH < 2) ? 2 : MAX_DEPTH;

	localparam int BYTE_W  = 8;
	localparam int INT_W   = 51;
	localparam int LEN_W   = 32;
	localparam int NEST_W  = 6;
	localparam int CODE_W  = 3;
	localparam int EV_W    = 3;
	localparam int FIELD_W = BYTE_W + INT_W + LEN_W + 1 + NEST_W + 1 + CODE_W;
	localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W   = DATA_W - FIELD_W;
	localparam int WIDE_W  = (ACC_W > INT_W) ? ACC_W : INT_W;

	// event codes
	localparam logic [EV_W-1:0] EV_NONE  = 3'd0;
	localparam logic [EV_W-1:0] EV_DICT  = 3'd1;
	localparam logic [EV_W-1:0] EV_LIST  = 3'd2;
	localparam logic [EV_W-1:0] EV_CLOSE = 3'd3;
	localparam logic [EV_W-1:0] EV_STR   = 3'd4;
	localparam logic [EV_W-1:0] EV_BYTE  = 3'd5;
	localparam logic [EV_W-1:0] EV_INT   = 3'd6;

	// error codes
	localparam logic [CODE_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [CODE_W-1:0] ERR_STR_FMT   = 3'd1;
	localparam logic [CODE_W-1:0] ERR_ZERO_LEN  = 3'd2;
	localparam logic [CODE_W-1:0] ERR_INT_FMT   = 3'd3;
	localparam logic [CODE_W-1:0] ERR_END       = 3'd4;
	localparam logic [CODE_W-1:0] ERR_DIGITS    = 3'd5;
	localparam logic [CODE_W-1:0] ERR_TOO_DEEP  = 3'd6;

	// characters
	localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
	localparam logic [BYTE_W-1:0] CH_L     = 8'h6c;
	localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	// result beat, last field in the lowest bits
	typedef struct packed {
		logic [PAD_W-1:0]  pad;
		logic [CODE_W-1:0] error_code;
		logic              doc_complete;
		logic [NEST_W-1:0] nesting;
		logic              is_key;
		logic [LEN_W-1:0]  string_length;
		logic [INT_W-1:0]  int_result;
		logic [BYTE_W-1:0] payload_byte;
	} out_data_t;

endpackage

`default_nettype wire

// File: src/bencode_stream_tokenizer.sv
// top level of the bencode stream tokenizer
`default_nettype none

// Reads a bencode document one byte per beat (tlast on the final byte) and
// answers every byte with exactly one token beat in the next cycle: container
// open and close, string start with its declared length, string payload
// bytes (tlast on the last one) and integers on their closing 'e'. The first
// error is held until the end byte, after which the block is ready for the
// next document. One byte is taken every cycle while the result register is
// empty or being drained; the digit accumulate is a shift-and-add in the
// same cycle and the container kinds sit in a shift register whose top
// bit is all the parser looks at.
module bencode_stream_tokenizer
	import bst_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,  // in_byte
	input  wire logic              s_axis_tlast,  // end_of_input
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// payload_byte, int_result, string_length, is_key, nesting,
	// doc_complete, error_code, zero fill
	output logic [DATA_W-1:0]      m_axis_tdata,
	output logic                   m_axis_tlast,  // payload_last
	output logic [EV_W-1:0]        m_axis_tuser   // event_res
);

	localparam logic [2:0] M_VALUE      = 3'd0;
	localparam logic [2:0] M_LEN        = 3'd1;
	localparam logic [2:0] M_PAYLOAD    = 3'd2;
	localparam logic [2:0] M_INT_START  = 3'd3;
	localparam logic [2:0] M_INT_SIGN   = 3'd4;
	localparam logic [2:0] M_INT_ZERO   = 3'd5;
	localparam logic [2:0] M_INT_DIGITS = 3'd6;
	localparam logic [2:0] M_DONE       = 3'd7;

	logic [2:0]         mode_q, mode_n;
	logic [STK_W-1:0]   stk_q, stk_n;
	logic [LEVEL_W-1:0] level_q, level_n;
	logic               expect_key_q, expect_key_n;
	logic               cur_key_q, cur_key_n;
	logic [ACC_W-1:0]   acc_q, acc_n;
	logic               neg_q, neg_n;
	logic [DCNT_W-1:0]  dcnt_q, dcnt_n;
	logic [LEN_W-1:0]   rem_q, rem_n, rem_dec;
	logic [CODE_W-1:0]  err_q, err_c;

	logic               m_valid_q, m_last_q;
	logic [EV_W-1:0]    m_user_q;
	out_data_t          m_data_q, res_d;

	logic               accept, eoi, is_dig, top_dict, dig_full, ok, finish;
	logic [BYTE_W-1:0]  b;
	logic [MUL_W-1:0]   acc_x, prod;
	logic [WIDE_W-1:0]  iv_ext, iv_val;
	logic [EV_W-1:0]    ev;
	logic               pl, dc, ik;
	logic [INT_W-1:0]   iv;
	logic [LEN_W-1:0]   sl;
	logic [2:0]         mode_after;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign b             = s_axis_tdata;
	assign eoi           = s_axis_tlast;
	assign is_dig        = (b >= CH_ZERO) && (b <= CH_NINE);
	assign top_dict      = (level_q != '0) && stk_q[0];
	assign dig_full      = dcnt_q >= DCNT_W'(DIGIT_LIMIT);
	assign acc_x         = MUL_W'(acc_q);
	assign prod          = (acc_x << 3) + (acc_x << 1) + MUL_W'(b[3:0]);
	assign iv_ext        = WIDE_W'(acc_q);
	assign iv_val        = neg_q ? (~iv_ext + WIDE_W'(1)) : iv_ext;
	assign rem_dec       = (rem_q == '0) ? '0 : rem_q - LEN_W'(1);

	always_comb begin
		mode_n       = mode_q;
		stk_n        = stk_q;
		level_n      = level_q;
		expect_key_n = expect_key_q;
		cur_key_n    = cur_key_q;
		acc_n        = acc_q;
		neg_n        = neg_q;
		dcnt_n       = dcnt_q;
		rem_n        = rem_q;
		err_c        = ERR_NONE;
		ev           = EV_NONE;
		pl           = 1'b0;
		dc           = 1'b0;
		ik           = 1'b0;
		iv           = '0;
		sl           = '0;
		finish       = 1'b0;

		unique case (mode_q)
			M_VALUE: begin
				if (top_dict && expect_key_q) begin
					if (b == CH_E) begin
						level_n = level_q - LEVEL_W'(1);
						stk_n   = stk_q >> 1;
						ev      = EV_CLOSE;
						finish  = 1'b1;
					end else if (is_dig) begin
						acc_n     = ACC_W'(b[3:0]);
						dcnt_n    = DCNT_W'(1);
						cur_key_n = 1'b1;
						mode_n    = M_LEN;
					end else begin
						err_c = ERR_STR_FMT;
					end
				end else if (b == CH_D || b == CH_L) begin
					if (level_q >= LEVEL_W'(MAX_DEPTH)) begin
						err_c = ERR_TOO_DEEP;
					end else begin
						stk_n   = {stk_q[STK_W-2:0], b == CH_D};
						level_n = level_q + LEVEL_W'(1);
						if (b == CH_D) begin
							expect_key_n = 1'b1;
							ev           = EV_DICT;
						end else begin
							ev = EV_LIST;
						end
					end
				end else if (b == CH_I) begin
					acc_n  = '0;
					neg_n  = 1'b0;
					dcnt_n = '0;
					mode_n = M_INT_START;
				end else if (is_dig) begin
					acc_n     = ACC_W'(b[3:0]);
					dcnt_n    = DCNT_W'(1);
					cur_key_n = 1'b0;
					mode_n    = M_LEN;
				end else if (b == CH_E && level_q != '0 && !top_dict) begin
					level_n = level_q - LEVEL_W'(1);
					stk_n   = stk_q >> 1;
					ev      = EV_CLOSE;
					finish  = 1'b1;
				end else begin
					err_c = ERR_STR_FMT;
				end
			end
			M_LEN: begin
				if (is_dig) begin
					if (dig_full || (|prod[MUL_W-1:LEN_W])) begin
						err_c = ERR_DIGITS;
					end else begin
						dcnt_n = dcnt_q + DCNT_W'(1);
						acc_n  = prod[ACC_W-1:0];
					end
				end else if (b == CH_COLON) begin
					if (acc_q == '0) begin
						err_c = ERR_ZERO_LEN;
					end else begin
						ev     = EV_STR;
						sl     = acc_q[LEN_W-1:0];
						ik     = cur_key_q;
						rem_n  = acc_q[LEN_W-1:0];
						mode_n = M_PAYLOAD;
					end
				end else begin
					err_c = ERR_STR_FMT;
				end
			end
			M_PAYLOAD: begin
				ev    = EV_BYTE;
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					pl     = 1'b1;
					finish = 1'b1;
				end
			end
			M_INT_START: begin
				if (b == CH_MINUS) begin
					neg_n  = 1'b1;
					dcnt_n = DCNT_W'(1);
					mode_n = M_INT_SIGN;
				end else if (b == CH_ZERO) begin
					dcnt_n = DCNT_W'(1);
					mode_n = M_INT_ZERO;
				end else if (is_dig) begin
					if (dig_full) begin
						err_c = ERR_DIGITS;
					end else begin
						dcnt_n = dcnt_q + DCNT_W'(1);
						acc_n  = prod[ACC_W-1:0];
						mode_n = M_INT_DIGITS;
					end
				end else begin
					err_c = ERR_INT_FMT;
				end
			end
			M_INT_SIGN: begin
				if (is_dig && b != CH_ZERO) begin
					if (dig_full) begin
						err_c = ERR_DIGITS;
					end else begin
						dcnt_n = dcnt_q + DCNT_W'(1);
						acc_n  = prod[ACC_W-1:0];
						mode_n = M_INT_DIGITS;
					end
				end else begin
					err_c = ERR_INT_FMT;
				end
			end
			M_INT_ZERO: begin
				if (b == CH_E) begin
					ev     = EV_INT;
					finish = 1'b1;
				end else begin
					err_c = ERR_INT_FMT;
				end
			end
			M_INT_DIGITS: begin
				if (is_dig) begin
					if (dig_full) begin
						err_c = ERR_DIGITS;
					end else begin
						dcnt_n = dcnt_q + DCNT_W'(1);
						acc_n  = prod[ACC_W-1:0];
					end
				end else if (b == CH_E) begin
					ev     = EV_INT;
					iv     = iv_val[INT_W-1:0];
					finish = 1'b1;
				end else begin
					err_c = ERR_INT_FMT;
				end
			end
			default: begin
			end
		endcase

		// value complete: pop back to the enclosing container or end the document
		if (finish) begin
			cur_key_n = 1'b0;
			if (level_n == '0) begin
				mode_n = M_DONE;
				dc     = 1'b1;
			end else begin
				mode_n = M_VALUE;
				if (stk_n[0]) begin
					expect_key_n = !cur_key_q;
				end
			end
		end
	end

	assign ok         = (err_q == ERR_NONE) && (err_c == ERR_NONE);
	assign mode_after = ok ? mode_n : mode_q;

	always_comb begin
		res_d               = '0;
		res_d.payload_byte  = ok && ev == EV_BYTE ? b : '0;
		res_d.int_result    = ok ? iv : '0;
		res_d.string_length = ok ? sl : '0;
		res_d.is_key        = ok && ik;
		res_d.nesting       = NEST_W'(ok ? level_n : level_q);
		res_d.doc_complete  = ok && dc;
		priority if (err_q != ERR_NONE) begin
			res_d.error_code = err_q;
		end else if (err_c != ERR_NONE) begin
			res_d.error_code = err_c;
		end else if (eoi && mode_after != M_DONE) begin
			res_d.error_code = ERR_END;
		end else begin
			res_d.error_code = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_VALUE;
			level_q      <= '0;
			expect_key_q <= 1'b0;
			cur_key_q    <= 1'b0;
			acc_q        <= '0;
			neg_q        <= 1'b0;
			dcnt_q       <= '0;
			rem_q        <= '0;
			err_q        <= ERR_NONE;
		end else if (accept) begin
			if (eoi) begin
				mode_q       <= M_VALUE;
				level_q      <= '0;
				expect_key_q <= 1'b0;
				cur_key_q    <= 1'b0;
				acc_q        <= '0;
				neg_q        <= 1'b0;
				dcnt_q       <= '0;
				rem_q        <= '0;
				err_q        <= ERR_NONE;
			end else if (ok) begin
				mode_q       <= mode_n;
				level_q      <= level_n;
				expect_key_q <= expect_key_n;
				cur_key_q    <= cur_key_n;
				acc_q        <= acc_n;
				neg_q        <= neg_n;
				dcnt_q       <= dcnt_n;
				rem_q        <= rem_n;
			end else if (err_q == ERR_NONE) begin
				err_q <= err_c;
			end
		end
	end

	// container kinds, top of stack in bit 0
	always_ff @(posedge clk) begin
		if (accept && ok) begin
			stk_q <= stk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_data_q <= res_d;
			m_user_q <= ok ? ev : EV_NONE;
			m_last_q <= ok && pl;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

// File: src/bst_checker.sv
// port checks of the bencode stream tokenizer and their binding
`default_nettype none

module bst_checker
	import bst_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [DATA_W-1:0] m_axis_tdata,
	input wire logic              m_axis_tlast,
	input wire logic [EV_W-1:0]   m_axis_tuser
);

	out_data_t m_d;
	logic      in_beat;

	assign m_d     = m_axis_tdata;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// every input beat gives a result beat next cycle
	a_one_per_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> m_axis_tvalid)
		else $error("input beat without result");

	// input side only waits on a blocked result register
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without back pressure");

	// last payload marker only on string bytes
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_BYTE)
		else $error("payload last outside string byte");

	// latched errors silence events
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_d.error_code != ERR_NONE && m_d.error_code != ERR_END |->
		m_axis_tuser == EV_NONE && !m_d.doc_complete)
		else $error("event reported during error");

endmodule

bind bencode_stream_tokenizer bst_checker u_bst_checker (.*);

`default_nettype wire

// File: test/tb_bencode_stream_tokenizer.sv
// testbench for the bencode stream tokenizer: random documents, token scoreboard
`default_nettype none

module tb_bencode_stream_tokenizer;
	import bst_pkg::*;

	typedef enum logic [2:0] {
		PM_VALUE, PM_LEN, PM_PAYLOAD, PM_INT_START, PM_INT_SIGN, PM_INT_ZERO, PM_INT_DIGITS,
		PM_DONE
	} parse_mode_t;

	typedef struct packed {
		logic [EV_W-1:0] ev;
		logic            last;
		out_data_t       data;
	} token_t;

	class token_scoreboard;
		parse_mode_t       mode;
		bit                kinds[MAX_DEPTH];
		int unsigned       level;
		bit                want_key;
		bit                str_is_key;
		bit                neg;
		longint unsigned   accum;
		int unsigned       ndigits;
		longint unsigned   remaining;
		logic [CODE_W-1:0] held_err;
		bit                root_done;
		logic [EV_W-1:0]   cur_ev;
		token_t            expected_tokens[$];
		int                mismatches;

		function new();
			clear();
			mismatches = 0;
		endfunction

		function void clear();
			mode = PM_VALUE;
			foreach (kinds[i]) kinds[i] = 1'b0;
			level = 0;
			want_key = 1'b0;
			str_is_key = 1'b0;
			neg = 1'b0;
			accum = 0;
			ndigits = 0;
			remaining = 0;
			held_err = ERR_NONE;
		endfunction

		function bit is_digit(logic [BYTE_W-1:0] b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		function bit top_dict();
			return level > 0 && level <= MAX_DEPTH && kinds[level-1];
		endfunction

		function void value_done();
			if (level == 0) begin
				mode = PM_DONE;
				root_done = 1'b1;
			end else begin
				mode = PM_VALUE;
				if (top_dict())
					want_key = !str_is_key;
			end
			str_is_key = 1'b0;
		endfunction

		function void begin_len(logic [BYTE_W-1:0] b, bit key);
			accum = 64'(b - CH_ZERO);
			ndigits = 1;
			str_is_key = key;
			mode = PM_LEN;
		endfunction

		function logic [CODE_W-1:0] open_box(bit dict);
			if (level >= MAX_DEPTH)
				return ERR_TOO_DEEP;
			kinds[level] = dict;
			level++;
			if (dict)
				want_key = 1'b1;
			cur_ev = dict ? EV_DICT : EV_LIST;
			return ERR_NONE;
		endfunction

		function logic [CODE_W-1:0] push_digit(logic [BYTE_W-1:0] b);
			if (ndigits + 1 > DIGIT_LIMIT)
				return ERR_DIGITS;
			ndigits++;
			accum = accum * 64'd10 + 64'(b - CH_ZERO);
			return ERR_NONE;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b, logic eoi);
			token_t t;
			logic [CODE_W-1:0] err;
			logic [CODE_W-1:0] code;
			longint unsigned v;
			t = '0;
			err = ERR_NONE;
			cur_ev = EV_NONE;
			root_done = 1'b0;
			if (held_err == ERR_NONE) begin
				case (mode)
					PM_VALUE: begin
						if (top_dict() && want_key) begin
							if (b == CH_E) begin
								level--;
								cur_ev = EV_CLOSE;
								value_done();
							end else if (is_digit(b)) begin
								begin_len(b, 1'b1);
							end else begin
								err = ERR_STR_FMT;
							end
						end else if (b == CH_D) begin
							err = open_box(1'b1);
						end else if (b == CH_L) begin
							err = open_box(1'b0);
						end else if (b == CH_I) begin
							accum = 0;
							neg = 1'b0;
							ndigits = 0;
							mode = PM_INT_START;
						end else if (is_digit(b)) begin
							begin_len(b, 1'b0);
						end else if (b == CH_E && level > 0 && !top_dict()) begin
							level--;
							cur_ev = EV_CLOSE;
							value_done();
						end else begin
							err = ERR_STR_FMT;
						end
					end
					PM_LEN: begin
						if (is_digit(b)) begin
							err = push_digit(b);
							if (err == ERR_NONE && accum > 64'hFFFF_FFFF)
								err = ERR_DIGITS;
						end else if (b == CH_COLON) begin
							if (accum == 0) begin
								err = ERR_ZERO_LEN;
							end else begin
								cur_ev = EV_STR;
								t.data.string_length = accum[LEN_W-1:0];
								t.data.is_key = str_is_key;
								remaining = 64'(accum[LEN_W-1:0]);
								mode = PM_PAYLOAD;
							end
						end else begin
							err = ERR_STR_FMT;
						end
					end
					PM_PAYLOAD: begin
						cur_ev = EV_BYTE;
						t.data.payload_byte = b;
						if (remaining > 0)
							remaining--;
						if (remaining == 0) begin
							t.last = 1'b1;
							value_done();
						end
					end
					PM_INT_START: begin
						if (b == CH_MINUS) begin
							neg = 1'b1;
							ndigits = 1;
							mode = PM_INT_SIGN;
						end else if (b == CH_ZERO) begin
							ndigits = 1;
							mode = PM_INT_ZERO;
						end else if (is_digit(b)) begin
							err = push_digit(b);
							mode = PM_INT_DIGITS;
						end else begin
							err = ERR_INT_FMT;
						end
					end
					PM_INT_SIGN: begin
						if (is_digit(b) && b != CH_ZERO) begin
							err = push_digit(b);
							mode = PM_INT_DIGITS;
						end else begin
							err = ERR_INT_FMT;
						end
					end
					PM_INT_ZERO: begin
						if (b == CH_E) begin
							cur_ev = EV_INT;
							value_done();
						end else begin
							err = ERR_INT_FMT;
						end
					end
					PM_INT_DIGITS: begin
						if (is_digit(b)) begin
							err = push_digit(b);
						end else if (b == CH_E) begin
							cur_ev = EV_INT;
							v = neg ? (64'd0 - accum) : accum;
							t.data.int_result = v[INT_W-1:0];
							value_done();
						end else begin
							err = ERR_INT_FMT;
						end
					end
					default: ;
				endcase
				if (err != ERR_NONE) begin
					held_err = err;
					t = '0;
					cur_ev = EV_NONE;
					root_done = 1'b0;
				end
			end
			code = held_err;
			if (eoi && code == ERR_NONE && mode != PM_DONE)
				code = ERR_END;
			t.ev = cur_ev;
			t.data.nesting = NEST_W'(level);
			t.data.doc_complete = root_done;
			t.data.error_code = code;
			expected_tokens.push_back(t);
			if (eoi)
				clear();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function string show(token_t t);
			return $sformatf("ev=%0d last=%0b byte=%h int=%h len=%0d key=%0b nest=%0d done=%0b err=%0d",
				t.ev, t.last, t.data.payload_byte, t.data.int_result, t.data.string_length,
				t.data.is_key, t.data.nesting, t.data.doc_complete, t.data.error_code);
		endfunction

		function void check_result(logic [EV_W-1:0] ev, logic last, out_data_t d);
			token_t want;
			token_t got;
			got.ev = ev;
			got.last = last;
			got.data = d;
			if (expected_tokens.size() == 0) begin
				report($sformatf("beat with nothing pending: %s", show(got)));
				return;
			end
			want = expected_tokens.pop_front();
			if (want.ev !== got.ev || want.last !== got.last ||
			    want.data.payload_byte !== got.data.payload_byte ||
			    want.data.int_result !== got.data.int_result ||
			    want.data.string_length !== got.data.string_length ||
			    want.data.is_key !== got.data.is_key ||
			    want.data.nesting !== got.data.nesting ||
			    want.data.doc_complete !== got.data.doc_complete ||
			    want.data.error_code !== got.data.error_code ||
			    want.data.pad !== got.data.pad)
				report($sformatf("expected %s, got %s", show(want), show(got)));
		endfunction

		function int pending();
			return expected_tokens.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	wire logic           s_axis_tready;
	logic [BYTE_W-1:0]   s_axis_tdata = '0;
	logic                s_axis_tlast = 1'b0;
	wire logic           m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	wire logic [DATA_W-1:0] m_axis_tdata;
	wire logic           m_axis_tlast;
	wire logic [EV_W-1:0] m_axis_tuser;

	token_scoreboard   sb = new();
	int unsigned       src_idle = 0;
	int unsigned       dst_idle = 0;
	int unsigned       sent_bytes = 0;
	logic [BYTE_W-1:0] doc_q[$];

	bencode_stream_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= dst_idle);
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tlast, out_data_t'(m_axis_tdata));
	end

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_char();
		case ($urandom_range(9))
			0: return CH_D;
			1: return CH_L;
			2: return CH_I;
			3: return CH_E;
			4: return CH_COLON;
			5: return CH_MINUS;
			6: return CH_ZERO;
			7: return BYTE_W'(CH_ZERO + BYTE_W'($urandom_range(9)));
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	function automatic void put_str_leaf();
		int unsigned n;
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
		if ($urandom_range(7) == 0)
			doc_q.push_back(CH_ZERO);
		put_text($sformatf("%0d:", n));
		repeat (n) doc_q.push_back(BYTE_W'($urandom_range(255)));
	endfunction

	function automatic void put_int_leaf();
		int unsigned k;
		bit minus;
		if ($urandom_range(7) == 0) begin
			put_text("i0e");
			return;
		end
		minus = 1'($urandom_range(1));
		k = minus ? 14 : 15;
		if ($urandom_range(3) != 0)
			k = $urandom_range(k, 1);
		doc_q.push_back(CH_I);
		if (minus)
			doc_q.push_back(CH_MINUS);
		doc_q.push_back(BYTE_W'(CH_ZERO + BYTE_W'($urandom_range(9, 1))));
		repeat (k - 1) doc_q.push_back(BYTE_W'(CH_ZERO + BYTE_W'($urandom_range(9))));
		doc_q.push_back(CH_E);
	endfunction

	// well-formed value built without recursion, at most four containers deep
	function automatic void put_tree();
		bit kind_q[$];
		int left_q[$];
		bit first;
		bit done;
		int top;
		first = 1'b1;
		done = 1'b0;
		while (!done) begin
			top = kind_q.size() - 1;
			if (!first && left_q[top] == 0) begin
				doc_q.push_back(CH_E);
				void'(kind_q.pop_back());
				void'(left_q.pop_back());
				done = (kind_q.size() == 0);
			end else begin
				if (!first) begin
					left_q[top] = left_q[top] - 1;
					if (kind_q[top])
						put_str_leaf();
				end
				if (kind_q.size() < 4 && $urandom_range(99) < (first ? 80 : 35)) begin
					kind_q.push_back(1'($urandom_range(1)));
					doc_q.push_back(kind_q[kind_q.size()-1] ? CH_D : CH_L);
					left_q.push_back(int'($urandom_range(3)));
				end else begin
					if ($urandom_range(1) != 0)
						put_str_leaf();
					else
						put_int_leaf();
					done = (kind_q.size() == 0);
				end
				first = 1'b0;
			end
		end
	endfunction

	function automatic void put_special();
		case ($urandom_range(19))
			0: put_text("0:");
			1: put_text("ie");
			2: put_text("i-e");
			3: put_text("i03e");
			4: put_text("i-0e");
			5: put_text("i1234567890123456e");
			6: put_text("i-123456789012345e");
			7: put_text("4294967296:ab");
			8: put_text("0000000000000001:x");
			9: begin
				put_text("000000000000003:");
				repeat (3) doc_q.push_back(BYTE_W'($urandom_range(255)));
			end
			10: begin
				put_text("4294967295:");
				repeat ($urandom_range(4, 1)) doc_q.push_back(BYTE_W'($urandom_range(255)));
			end
			11: begin
				repeat (MAX_DEPTH + 1) doc_q.push_back(CH_L);
				doc_q.push_back(CH_E);
			end
			12: begin
				repeat (MAX_DEPTH) doc_q.push_back(CH_L);
				put_text("i5e");
				repeat (MAX_DEPTH) doc_q.push_back(CH_E);
			end
			13: put_text("di1ei2ee");
			14: put_text(":");
			15: put_text("e");
			16: put_text("d1:ae");
			17: put_text("3x:abc");
			18: put_text("i12ae");
			default: put_text(($urandom_range(1) != 0) ? "i999999999999999e" : "i-99999999999999e");
		endcase
	endfunction

	function automatic void gen_doc();
		int unsigned r;
		int unsigned keep;
		doc_q.delete();
		r = $urandom_range(99);
		if (r < 78) begin
			put_tree();
			if (r < 60) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(3, 1)) doc_q.push_back(BYTE_W'($urandom_range(255)));
			end else if (r < 70) begin
				doc_q[$urandom_range(doc_q.size() - 1)] = pick_char();
			end else if (doc_q.size() > 1) begin
				keep = $urandom_range(doc_q.size() - 1, 1);
				while (doc_q.size() > keep)
					void'(doc_q.pop_back());
			end
		end else if (r < 92) begin
			put_special();
		end else begin
			repeat ($urandom_range(8, 1)) doc_q.push_back(pick_char());
		end
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		sent_bytes++;
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc_q.size(); i++)
			send_byte(doc_q[i], i == doc_q.size() - 1);
	endtask

	initial begin
		string directed_docs[5];
		int unsigned phase_src[3];
		int unsigned phase_dst[3];
		directed_docs = '{"li-7ee", ":", "i-e", "3:a", "i0ex"};
		phase_src = '{13, 74, 0};
		phase_dst = '{74, 13, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < 3; p++) begin
			src_idle = phase_src[p];
			dst_idle = phase_dst[p];
			if (p == 0) begin
				doc_q.delete();
				put_text("d1:k2:");
				doc_q.push_back(8'h00);
				doc_q.push_back(8'hff);
				put_text("e");
				send_doc();
				foreach (directed_docs[i]) begin
					doc_q.delete();
					put_text(directed_docs[i]);
					send_doc();
				end
			end
			while (sent_bytes < (p + 1) * 583) begin
				gen_doc();
				send_doc();
			end
		end
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("bencode_stream_tokenizer verification clean");
		else
			$display("bencode_stream_tokenizer verification failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("bencode_stream_tokenizer verification failed");
		$finish;
	end

endmodule

`default_nettype wire
